[rtl/vtb_pkg.sv]
// Shared types and constants of the virtual trackball rotation block.
// Depends on nothing; imported by the top level.
package vtb_pkg;

    localparam int ACC_W = 64;
    localparam int OP_W  = 32;
    localparam int OUT_W = 16;
    localparam int WIN_W = 13;

    typedef logic signed [ACC_W-1:0] t_acc;
    typedef logic signed [OP_W-1:0]  t_op;
    typedef logic [1:0]              t_cmd;

    // Event kinds
    localparam t_cmd CMD_PRESS   = 2'd0;
    localparam t_cmd CMD_MOVE    = 2'd1;
    localparam t_cmd CMD_RELEASE = 2'd2;

    // Register indexes
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    localparam logic [WIN_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [WIN_W-1:0] HEIGHT_RESET = 13'd480;

    // Press offsets in Q0.32
    localparam logic [63:0] OFFSET_X_Q32 = 64'd57327888;
    localparam logic [63:0] OFFSET_Y_Q32 = 64'd149201831;

endpackage

[rtl/virtual_trackball_rotation.sv]
// Virtual trackball rotation: pointer events to a 3x3 rotation matrix.
// Depends on vtb_pkg for types, command codes and constants.
//
// Each accepted item (press, move or release with pixel coordinates) gives
// exactly one result: the active flag and the shown Q1.FRAC_BITS matrix.
// One item is worked at a time; the input is not ready until the result
// has been handed to the output register, which may still wait for the
// sink while the next item is taken. All arithmetic runs through one
// shared 32x32 multiplier, one restoring divider and one bit-pair square
// root under a sequencer. A press needs two quotients and one root, four
// quotients on the rim; a move or release with a nonzero axis needs five
// quotients, seven on the rim, and three roots. Window size registers are
// written through the plain write port; the user must do so only while
// the block is idle, which the block itself does not enforce.
module virtual_trackball_rotation
    import vtb_pkg::*;
#(
    parameter int FRAC_BITS  = 14,
    parameter int COORD_BITS = 12
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_idx,
    input  logic [WIN_W-1:0]       i_cfg_data,
    // event items
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  t_cmd                   i_cmd,
    input  logic [COORD_BITS-1:0]  i_pos_x,
    input  logic [COORD_BITS-1:0]  i_pos_y,
    // result items
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic                   o_active,
    output logic signed [OUT_W-1:0] o_rot_00,
    output logic signed [OUT_W-1:0] o_rot_01,
    output logic signed [OUT_W-1:0] o_rot_02,
    output logic signed [OUT_W-1:0] o_rot_10,
    output logic signed [OUT_W-1:0] o_rot_11,
    output logic signed [OUT_W-1:0] o_rot_12,
    output logic signed [OUT_W-1:0] o_rot_20,
    output logic signed [OUT_W-1:0] o_rot_21,
    output logic signed [OUT_W-1:0] o_rot_22
);

    localparam t_acc        ONE        = t_acc'(64'd1 << FRAC_BITS);
    localparam t_op         ONE_OP     = t_op'(64'd1 << FRAC_BITS);
    localparam t_acc        ONE_SQ     = t_acc'(64'd1 << (2 * FRAC_BITS));
    localparam logic [63:0] HALF       = 64'd1 << (FRAC_BITS - 1);
    localparam logic [63:0] FOLD_LIMIT = 64'd1 << 30;
    localparam logic [63:0] SQRT_TOP   = 64'd1 << 62;
    localparam logic [63:0] OFF_X =
        (OFFSET_X_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
    localparam logic [63:0] OFF_Y =
        (OFFSET_Y_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);

    typedef enum logic [4:0] {
        S_IDLE, S_MAPX, S_MAPY, S_MAPC, S_FOLD, S_SQ, S_SQD, S_ZDONE,
        S_RIMX, S_RIMY, S_RIMZ, S_PDONE, S_CROSS, S_AZ, S_LSQ, S_LEN,
        S_NORM, S_NORMW, S_SIN, S_RSET, S_ROT, S_MAT, S_COMMIT, S_OUT,
        S_DIV, S_SQRT
    } t_state;

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    function automatic logic [63:0] mag(input t_acc v);
        mag = v[63] ? 64'(-v) : 64'(v);
    endfunction

    function automatic t_acc rnd_sh(input t_acc v);
        logic [63:0] m;
        m = v[63] ? 64'(-v) : 64'(v);
        m = (m + HALF) >> FRAC_BITS;
        rnd_sh = v[63] ? -t_acc'(m) : t_acc'(m);
    endfunction

    function automatic t_op sat1(input t_acc v);
        if (v > ONE) begin
            sat1 = ONE_OP;
        end else if (v < -ONE) begin
            sat1 = -ONE_OP;
        end else begin
            sat1 = t_op'(v);
        end
    endfunction

    function automatic t_op sgn(input logic [63:0] m, input logic neg);
        sgn = neg ? -t_op'(m) : t_op'(m);
    endfunction

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state            r_state, r_ret;
    logic [WIN_W-1:0]  r_w, r_h;
    t_cmd              r_cmd;
    logic [63:0]       r_px, r_py;
    t_acc              r_x, r_y;
    logic [63:0]       r_ax, r_ay;
    logic              r_small;
    t_op               r_cur [3];
    t_op               r_sp  [3];
    t_op               r_a   [3];
    t_op               r_n   [3];
    t_op               r_d, r_sn, r_tmp;
    t_op               r_rot [9];
    t_op               r_cm  [9];
    t_op               r_sm  [9];
    logic              r_held;
    t_acc              r_acc, r_prod;
    logic [1:0]        r_t, r_i, r_j;
    logic [1:0]        r_g;
    logic              r_ph;
    logic [31:0]       r_len;
    // divider
    logic [31:0]       r_dden, r_rem;
    logic [63:0]       r_quo;
    logic [5:0]        r_cnt;
    // square root
    logic [63:0]       r_sv, r_sr, r_sbit;
    // output register
    logic              r_ovalid, r_oact;
    logic signed [OUT_W-1:0] r_out [9];

    // ------------------------------------------------------------------
    // Combinational datapath
    // ------------------------------------------------------------------
    logic [WIN_W-1:0]  w_weff, w_heff;
    logic [63:0]       w_px_in, w_py_in;
    t_acc              w_yq;
    logic [31:0]       w_len;
    t_op               w_ma, w_mb, w_ni, w_nj, w_k;
    t_acc              w_mul, w_cacc, w_sacc, w_rv;
    logic [3:0]        w_ij, w_ra, w_rb;
    logic              w_last, w_sub;
    logic [32:0]       w_rem_sh;
    logic              w_div_ge;
    logic [63:0]       w_sq_sum;
    logic              w_sq_ge;
    logic              w_sm_ok;

    assign w_weff  = (r_w == '0) ? WIN_W'(1) : r_w;
    assign w_heff  = (r_h == '0) ? WIN_W'(1) : r_h;
    assign w_px_in = ({{(64-COORD_BITS){1'b0}}, i_pos_x} << FRAC_BITS) +
                     ((i_cmd == CMD_PRESS) ? OFF_X : 64'd0);
    assign w_py_in = ({{(64-COORD_BITS){1'b0}}, i_pos_y} << FRAC_BITS) +
                     ((i_cmd == CMD_PRESS) ? OFF_Y : 64'd0);
    assign w_yq    = ONE - t_acc'(r_quo);
    assign w_len   = (r_sr == 64'd0) ? 32'd1 : r_sr[31:0];

    // Flat matrix indexes: row i col j, rot row i col t, committed row t col j
    assign w_ij = {1'b0, r_i, 1'b0} + {2'b00, r_i} + {2'b00, r_j};
    assign w_ra = {1'b0, r_i, 1'b0} + {2'b00, r_i} + {2'b00, r_t};
    assign w_rb = {1'b0, r_t, 1'b0} + {2'b00, r_t} + {2'b00, r_j};

    // Pick axis components for row and column
    always_comb begin
        unique case (r_i)
            2'd0:    w_ni = r_n[0];
            2'd1:    w_ni = r_n[1];
            default: w_ni = r_n[2];
        endcase
        unique case (r_j)
            2'd0:    w_nj = r_n[0];
            2'd1:    w_nj = r_n[1];
            default: w_nj = r_n[2];
        endcase
        // skew-symmetric cross-product matrix of the axis
        unique case ({r_i, r_j})
            4'b0001: w_k = -r_n[2];
            4'b0010: w_k = r_n[1];
            4'b0100: w_k = r_n[2];
            4'b0110: w_k = -r_n[0];
            4'b1000: w_k = -r_n[1];
            4'b1001: w_k = r_n[0];
            default: w_k = '0;
        endcase
    end

    // Operand select for the shared multiplier
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            S_SQ: begin
                w_ma = r_t[0] ? t_op'({2'b00, r_ay[29:0]}) : t_op'({2'b00, r_ax[29:0]});
                w_mb = w_ma;
            end
            S_CROSS: begin
                unique case ({r_g, r_t[0]})
                    3'b000: begin w_ma = r_sp[1]; w_mb = r_cur[2]; end
                    3'b001: begin w_ma = r_sp[2]; w_mb = r_cur[1]; end
                    3'b010: begin w_ma = r_sp[2]; w_mb = r_cur[0]; end
                    3'b011: begin w_ma = r_sp[0]; w_mb = r_cur[2]; end
                    3'b100: begin w_ma = r_sp[0]; w_mb = r_cur[1]; end
                    3'b101: begin w_ma = r_sp[1]; w_mb = r_cur[0]; end
                    default: begin
                        w_ma = r_sp[r_t];
                        w_mb = r_cur[r_t];
                    end
                endcase
            end
            S_LSQ: begin
                w_ma = r_a[r_t];
                w_mb = r_a[r_t];
            end
            S_SIN: begin
                w_ma = r_d;
                w_mb = r_d;
            end
            S_ROT: begin
                unique case (r_t)
                    2'd0: begin w_ma = w_ni; w_mb = w_nj; end
                    2'd1: begin w_ma = ONE_OP - r_d; w_mb = r_tmp; end
                    default: begin w_ma = r_sn; w_mb = w_k; end
                endcase
            end
            S_MAT: begin
                w_ma = r_rot[w_ra];
                w_mb = r_cm[w_rb];
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_mul = t_acc'(w_ma) * t_acc'(w_mb);

    // Cross/dot accumulation: second term of a cross component subtracts
    assign w_sub  = (r_g != 2'd3) && (r_t == 2'd1);
    assign w_last = (r_g == 2'd3) ? (r_t == 2'd2) : (r_t == 2'd1);
    assign w_cacc = w_sub ? (r_acc - r_prod) : (r_acc + r_prod);
    assign w_sacc = r_acc + r_prod;
    assign w_rv   = r_acc + rnd_sh(r_prod) + ((r_i == r_j) ? t_acc'(r_d) : t_acc'(0));

    // Divider and square root step
    assign w_rem_sh = {r_rem, r_quo[63]};
    assign w_div_ge = w_rem_sh >= {1'b0, r_dden};
    assign w_sq_sum = r_sr + r_sbit;
    assign w_sq_ge  = r_sv >= w_sq_sum;

    // Shown matrix stays inside [-ONE, ONE]
    always_comb begin
        w_sm_ok = 1'b1;
        for (int k = 0; k < 9; k++) begin
            if (r_sm[k] > ONE_OP || r_sm[k] < -ONE_OP) begin
                w_sm_ok = 1'b0;
            end
        end
    end

    // Hold the product of the selected operands for the next cycle
    always_ff @(posedge i_clk) begin
        r_prod <= w_mul;
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_held   <= 1'b0;
            r_ovalid <= 1'b0;
            r_w      <= WIDTH_RESET;
            r_h      <= HEIGHT_RESET;
            for (int k = 0; k < 3; k++) begin
                r_sp[k] <= '0;
            end
            for (int k = 0; k < 9; k++) begin
                r_cm[k] <= (k % 4 == 0) ? ONE_OP : t_op'(0);
                r_sm[k] <= (k % 4 == 0) ? ONE_OP : t_op'(0);
            end
        end else begin
            // take register writes
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_WIDTH) begin
                    r_w <= i_cfg_data;
                end else begin
                    r_h <= i_cfg_data;
                end
            end

            // drop the result once taken, unless a new one is loaded below
            if (r_ovalid && i_out_ready && r_state != S_OUT) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd <= i_cmd;
                        r_px  <= w_px_in;
                        r_py  <= w_py_in;
                        if (i_cmd == CMD_PRESS ||
                            ((i_cmd == CMD_MOVE || i_cmd == CMD_RELEASE) && r_held)) begin
                            r_state <= S_MAPX;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end
                end

                // map x: round(2p / w) - ONE
                S_MAPX: begin
                    r_quo   <= (r_px << 1) + 64'(w_weff >> 1);
                    r_rem   <= '0;
                    r_dden  <= 32'(w_weff);
                    r_cnt   <= '0;
                    r_ret   <= S_MAPY;
                    r_state <= S_DIV;
                end

                // map y: ONE - round(2q / h)
                S_MAPY: begin
                    r_x     <= t_acc'(r_quo) - ONE;
                    r_quo   <= (r_py << 1) + 64'(w_heff >> 1);
                    r_rem   <= '0;
                    r_dden  <= 32'(w_heff);
                    r_cnt   <= '0;
                    r_ret   <= S_MAPC;
                    r_state <= S_DIV;
                end

                S_MAPC: begin
                    r_y     <= w_yq;
                    r_ax    <= mag(r_x);
                    r_ay    <= mag(w_yq);
                    r_small <= (mag(r_x) <= 64'(ONE)) && (mag(w_yq) <= 64'(ONE));
                    r_state <= S_FOLD;
                end

                // shift large magnitudes down together
                S_FOLD: begin
                    if ((r_ax | r_ay) >= FOLD_LIMIT) begin
                        r_ax <= r_ax >> 1;
                        r_ay <= r_ay >> 1;
                    end else begin
                        r_t     <= '0;
                        r_ph    <= 1'b0;
                        r_acc   <= '0;
                        r_state <= S_SQ;
                    end
                end

                // ax^2 + ay^2
                S_SQ: begin
                    if (!r_ph) begin
                        r_ph <= 1'b1;
                    end else begin
                        r_ph  <= 1'b0;
                        r_acc <= w_sacc;
                        if (r_t == 2'd1) begin
                            r_state <= S_SQD;
                        end else begin
                            r_t <= r_t + 2'd1;
                        end
                    end
                end

                // inside the disk: z from the sphere, else length to the rim
                S_SQD: begin
                    r_sr    <= '0;
                    r_sbit  <= SQRT_TOP;
                    r_state <= S_SQRT;
                    if (r_small && r_acc <= ONE_SQ) begin
                        r_sv  <= 64'(ONE_SQ - r_acc);
                        r_ret <= S_ZDONE;
                    end else begin
                        r_sv  <= 64'(r_acc);
                        r_ret <= S_RIMX;
                    end
                end

                S_ZDONE: begin
                    r_cur[0] <= t_op'(r_x);
                    r_cur[1] <= t_op'(r_y);
                    r_cur[2] <= t_op'(r_sr);
                    r_state  <= S_PDONE;
                end

                // project onto the rim
                S_RIMX: begin
                    r_len   <= w_len;
                    r_quo   <= (r_ax << FRAC_BITS) + 64'(w_len >> 1);
                    r_rem   <= '0;
                    r_dden  <= w_len;
                    r_cnt   <= '0;
                    r_ret   <= S_RIMY;
                    r_state <= S_DIV;
                end

                S_RIMY: begin
                    r_cur[0] <= sgn(r_quo, r_x[63]);
                    r_quo    <= (r_ay << FRAC_BITS) + 64'(r_len >> 1);
                    r_rem    <= '0;
                    r_dden   <= r_len;
                    r_cnt    <= '0;
                    r_ret    <= S_RIMZ;
                    r_state  <= S_DIV;
                end

                S_RIMZ: begin
                    r_cur[1] <= sgn(r_quo, r_y[63]);
                    r_cur[2] <= '0;
                    r_state  <= S_PDONE;
                end

                // press stores the start point; move/release build a rotation
                S_PDONE: begin
                    if (r_cmd == CMD_PRESS) begin
                        r_sp    <= r_cur;
                        r_held  <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_g     <= '0;
                        r_t     <= '0;
                        r_ph    <= 1'b0;
                        r_acc   <= '0;
                        r_state <= S_CROSS;
                    end
                end

                // cross product components, then clamped dot product
                S_CROSS: begin
                    if (!r_ph) begin
                        r_ph <= 1'b1;
                    end else begin
                        r_ph <= 1'b0;
                        if (w_last) begin
                            r_acc <= '0;
                            r_t   <= '0;
                            if (r_g == 2'd3) begin
                                r_d     <= sat1(rnd_sh(w_cacc));
                                r_state <= S_AZ;
                            end else begin
                                r_a[r_g] <= t_op'(rnd_sh(w_cacc));
                                r_g      <= r_g + 2'd1;
                            end
                        end else begin
                            r_acc <= w_cacc;
                            r_t   <= r_t + 2'd1;
                        end
                    end
                end

                // zero axis gives identity
                S_AZ: begin
                    r_t   <= '0;
                    r_ph  <= 1'b0;
                    r_acc <= '0;
                    if (r_a[0] == '0 && r_a[1] == '0 && r_a[2] == '0) begin
                        for (int k = 0; k < 9; k++) begin
                            r_rot[k] <= (k % 4 == 0) ? ONE_OP : t_op'(0);
                        end
                        r_i     <= '0;
                        r_j     <= '0;
                        r_state <= S_MAT;
                    end else begin
                        r_state <= S_LSQ;
                    end
                end

                // axis length squared, then its root
                S_LSQ: begin
                    if (!r_ph) begin
                        r_ph <= 1'b1;
                    end else begin
                        r_ph <= 1'b0;
                        if (r_t == 2'd2) begin
                            r_sv    <= 64'(w_sacc);
                            r_sr    <= '0;
                            r_sbit  <= SQRT_TOP;
                            r_ret   <= S_LEN;
                            r_state <= S_SQRT;
                        end else begin
                            r_acc <= w_sacc;
                            r_t   <= r_t + 2'd1;
                        end
                    end
                end

                S_LEN: begin
                    r_len   <= w_len;
                    r_t     <= '0;
                    r_state <= S_NORM;
                end

                // normalize one axis component
                S_NORM: begin
                    r_quo   <= (mag(t_acc'(r_a[r_t])) << FRAC_BITS) + 64'(r_len >> 1);
                    r_rem   <= '0;
                    r_dden  <= r_len;
                    r_cnt   <= '0;
                    r_ret   <= S_NORMW;
                    r_state <= S_DIV;
                end

                S_NORMW: begin
                    r_n[r_t] <= sgn(r_quo, r_a[r_t][OP_W-1]);
                    if (r_t == 2'd2) begin
                        r_ph    <= 1'b0;
                        r_state <= S_SIN;
                    end else begin
                        r_t     <= r_t + 2'd1;
                        r_state <= S_NORM;
                    end
                end

                // sine from the clamped cosine
                S_SIN: begin
                    if (!r_ph) begin
                        r_ph <= 1'b1;
                    end else begin
                        r_ph    <= 1'b0;
                        r_sv    <= 64'(ONE_SQ - r_prod);
                        r_sr    <= '0;
                        r_sbit  <= SQRT_TOP;
                        r_ret   <= S_RSET;
                        r_state <= S_SQRT;
                    end
                end

                S_RSET: begin
                    r_sn    <= t_op'(r_sr);
                    r_i     <= '0;
                    r_j     <= '0;
                    r_t     <= '0;
                    r_ph    <= 1'b0;
                    r_state <= S_ROT;
                end

                // rotation entry: (1-c) n_i n_j + s k_ij, plus c on the diagonal
                S_ROT: begin
                    if (!r_ph) begin
                        r_ph <= 1'b1;
                    end else begin
                        r_ph <= 1'b0;
                        unique case (r_t)
                            2'd0: begin
                                r_tmp <= t_op'(rnd_sh(r_prod));
                                r_t   <= 2'd1;
                            end
                            2'd1: begin
                                r_acc <= rnd_sh(r_prod);
                                r_t   <= 2'd2;
                            end
                            default: begin
                                r_rot[w_ij] <= sat1(w_rv);
                                r_t         <= '0;
                                r_acc       <= '0;
                                if (r_j == 2'd2) begin
                                    r_j <= '0;
                                    if (r_i == 2'd2) begin
                                        r_i     <= '0;
                                        r_state <= S_MAT;
                                    end else begin
                                        r_i <= r_i + 2'd1;
                                    end
                                end else begin
                                    r_j <= r_j + 2'd1;
                                end
                            end
                        endcase
                    end
                end

                // shown = rotation * committed
                S_MAT: begin
                    if (!r_ph) begin
                        r_ph <= 1'b1;
                    end else begin
                        r_ph <= 1'b0;
                        if (r_t == 2'd2) begin
                            r_sm[w_ij] <= sat1(rnd_sh(w_sacc));
                            r_acc      <= '0;
                            r_t        <= '0;
                            if (r_j == 2'd2) begin
                                r_j <= '0;
                                if (r_i == 2'd2) begin
                                    r_i     <= '0;
                                    r_state <= S_COMMIT;
                                end else begin
                                    r_i <= r_i + 2'd1;
                                end
                            end else begin
                                r_j <= r_j + 2'd1;
                            end
                        end else begin
                            r_acc <= w_sacc;
                            r_t   <= r_t + 2'd1;
                        end
                    end
                end

                // release commits the shown matrix
                S_COMMIT: begin
                    if (r_cmd == CMD_RELEASE) begin
                        r_cm   <= r_sm;
                        r_held <= 1'b0;
                    end
                    r_state <= S_OUT;
                end

                // load the output register once it is free
                S_OUT: begin
                    if (!r_ovalid || i_out_ready) begin
                        r_ovalid <= 1'b1;
                        r_oact   <= r_held;
                        for (int k = 0; k < 9; k++) begin
                            r_out[k] <= r_sm[k][OUT_W-1:0];
                        end
                        r_state <= S_IDLE;
                    end
                end

                // restoring divide, one quotient bit per cycle
                S_DIV: begin
                    if (w_div_ge) begin
                        r_rem <= 32'(w_rem_sh - {1'b0, r_dden});
                    end else begin
                        r_rem <= w_rem_sh[31:0];
                    end
                    r_quo <= {r_quo[62:0], w_div_ge};
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd63) begin
                        r_state <= r_ret;
                    end
                end

                // floor square root, one result bit per cycle
                S_SQRT: begin
                    if (r_sbit == 64'd0) begin
                        r_state <= r_ret;
                    end else begin
                        if (w_sq_ge) begin
                            r_sv <= r_sv - w_sq_sum;
                            r_sr <= (r_sr >> 1) + r_sbit;
                        end else begin
                            r_sr <= r_sr >> 1;
                        end
                        r_sbit <= r_sbit >> 2;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Outputs
    // ------------------------------------------------------------------
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_active    = r_oact;
    assign o_rot_00    = r_out[0];
    assign o_rot_01    = r_out[1];
    assign o_rot_02    = r_out[2];
    assign o_rot_10    = r_out[3];
    assign o_rot_11    = r_out[4];
    assign o_rot_12    = r_out[5];
    assign o_rot_20    = r_out[6];
    assign o_rot_21    = r_out[7];
    assign o_rot_22    = r_out[8];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_dden))
        else $error("divider remainder not below divisor");

    a_sqrt_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQRT) |-> $onehot0(r_sbit))
        else $error("square root bit lost its single set position");

    a_sm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sm_ok)
        else $error("shown matrix entry outside unit range");

    a_release_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMMIT && r_cmd == CMD_RELEASE) |=> !r_held)
        else $error("release did not drop the held flag");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("sequencer stayed idle after taking an item");

endmodule
